// ===== rtl/tos_pkg.sv =====
package tos_pkg;

  localparam int NAME_MAX_DEFAULT = 32;
  // wide enough for the largest supported name length (63)
  localparam int CNT_W = 6;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CODE_IAC = 8'hFF;
  localparam logic [7:0] CODE_SB  = 8'hFA;
  localparam logic [7:0] CODE_SE  = 8'hF0;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_U   = 8'h55;
  localparam logic [7:0] CHAR_LBR = 8'h5B;
  localparam logic [7:0] CHAR_RBR = 8'h5D;

  localparam logic [2:0] PROG_IDLE    = 3'd0;
  localparam logic [2:0] PROG_OPEN    = 3'd1;
  localparam logic [2:0] PROG_U_SEEN  = 3'd2;
  localparam logic [2:0] PROG_COLLECT = 3'd6;

  typedef enum logic [1:0] {
    MODE_NORMAL    = 2'd0,
    MODE_AFTER_IAC = 2'd1,
    MODE_SKIP      = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_TEXT    = 2'd0,
    KIND_DISCARD = 2'd1,
    KIND_END     = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_CR    = 3'd0,
    PH_OPEN  = 3'd1,
    PH_NAME  = 3'd2,
    PH_CLOSE = 3'd3,
    PH_NL    = 3'd4,
    PH_MAIN  = 3'd5,
    PH_END   = 3'd6
  } phase_t;

  localparam int NUM_PH = 7;

  // everything one input byte asks the back end to do
  typedef struct packed {
    logic             cr_valid;
    logic [7:0]       cr_byte;
    logic             burst;
    logic [CNT_W-1:0] name_count;
    logic             name_ovf;
    logic             store;
    logic [CNT_W-1:0] store_idx;
    logic [7:0]       store_byte;
    logic             main_valid;
    kind_t            main_kind;
    logic [7:0]       main_byte;
    logic             end_item;
  } entry_t;

  function automatic logic [7:0] user_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h55;
      3'd1:    c = 8'h53;
      3'd2:    c = 8'h45;
      3'd3:    c = 8'h52;
      3'd4:    c = 8'h01;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/tos_front.sv =====
module tos_front #(
  parameter int NAME_MAX = tos_pkg::NAME_MAX_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            q_ready,
  output logic            q_push,
  output tos_pkg::entry_t q_entry
);

  localparam logic [tos_pkg::CNT_W-1:0] NM = tos_pkg::CNT_W'(NAME_MAX);

  tos_pkg::mode_t             mode, mode_next;
  logic                       in_sub, in_sub_next;
  logic                       pend, pend_next;
  logic [2:0]                 prog, prog_next;
  logic [tos_pkg::CNT_W-1:0]  cnt, cnt_next;
  logic                       ovf, ovf_next;
  logic [2:0]                 matched;

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;
  assign matched  = prog - 3'd1;

  // work list for this byte
  always_comb begin
    q_entry = '0;
    q_entry.cr_valid   = pend;
    q_entry.cr_byte    = (in_byte == tos_pkg::CHAR_LF) ? tos_pkg::CHAR_CR : tos_pkg::CHAR_LF;
    q_entry.name_count = cnt;
    q_entry.name_ovf   = ovf;
    q_entry.store_idx  = cnt;
    q_entry.store_byte = in_byte;
    q_entry.main_kind  = tos_pkg::KIND_TEXT;
    q_entry.main_byte  = in_byte;
    q_entry.end_item   = in_last;
    if (prog == tos_pkg::PROG_COLLECT) begin
      if (in_byte == tos_pkg::CODE_IAC) begin
        q_entry.burst = 1'b1;
      end else if (cnt < NM) begin
        q_entry.store = 1'b1;
      end
    end
    unique case (mode)
      tos_pkg::MODE_AFTER_IAC: begin
        if (in_byte == tos_pkg::CODE_SE && !in_sub) begin
          q_entry.main_valid = 1'b1;
          q_entry.main_kind  = tos_pkg::KIND_DISCARD;
          q_entry.main_byte  = 8'h00;
        end
      end
      tos_pkg::MODE_SKIP: begin
      end
      default: begin
        if (in_byte != tos_pkg::CODE_IAC && !in_sub) begin
          if (in_byte == tos_pkg::CHAR_CR) begin
            q_entry.main_valid = in_last;
          end else begin
            q_entry.main_valid = (in_byte != tos_pkg::CHAR_NUL);
          end
        end
      end
    endcase
  end

  always_comb begin
    mode_next   = tos_pkg::MODE_NORMAL;
    in_sub_next = in_sub;
    pend_next   = 1'b0;
    prog_next   = prog;
    cnt_next    = cnt;
    ovf_next    = ovf;
    // name window
    if (prog != tos_pkg::PROG_IDLE) begin
      if (in_byte == tos_pkg::CODE_IAC) begin
        prog_next = tos_pkg::PROG_IDLE;
        cnt_next  = '0;
        ovf_next  = 1'b0;
      end else if (prog == tos_pkg::PROG_COLLECT) begin
        if (cnt < NM) begin
          cnt_next = cnt + tos_pkg::CNT_W'(1);
        end else begin
          ovf_next = 1'b1;
        end
      end else if (matched < 3'd5 && in_byte == tos_pkg::user_char(matched)) begin
        prog_next = prog + 3'd1;
      end else begin
        prog_next = (in_byte == tos_pkg::CHAR_U) ? tos_pkg::PROG_U_SEEN : tos_pkg::PROG_OPEN;
      end
    end
    // command parser
    unique case (mode)
      tos_pkg::MODE_AFTER_IAC: begin
        if (in_byte > tos_pkg::CODE_SB) begin
          mode_next = tos_pkg::MODE_SKIP;
        end else if (in_byte == tos_pkg::CODE_SB) begin
          in_sub_next = 1'b1;
          prog_next   = tos_pkg::PROG_OPEN;
          cnt_next    = '0;
          ovf_next    = 1'b0;
        end else if (in_byte == tos_pkg::CODE_SE) begin
          in_sub_next = 1'b0;
        end
      end
      tos_pkg::MODE_SKIP: begin
      end
      default: begin
        if (in_byte == tos_pkg::CODE_IAC) begin
          mode_next = tos_pkg::MODE_AFTER_IAC;
        end else if (!in_sub && in_byte == tos_pkg::CHAR_CR && !in_last) begin
          pend_next = 1'b1;
        end
      end
    endcase
    // each buffer stands alone
    if (in_last) begin
      mode_next   = tos_pkg::MODE_NORMAL;
      in_sub_next = 1'b0;
      pend_next   = 1'b0;
      prog_next   = tos_pkg::PROG_IDLE;
      cnt_next    = '0;
      ovf_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= tos_pkg::MODE_NORMAL;
      in_sub <= 1'b0;
      pend   <= 1'b0;
      prog   <= tos_pkg::PROG_IDLE;
      cnt    <= '0;
      ovf    <= 1'b0;
    end else if (q_push) begin
      mode   <= mode_next;
      in_sub <= in_sub_next;
      pend   <= pend_next;
      prog   <= prog_next;
      cnt    <= cnt_next;
      ovf    <= ovf_next;
    end
  end

endmodule

// ===== rtl/tos_queue.sv =====
module tos_queue #(
  parameter int W     = 8,
  parameter int DEPTH = tos_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         ready,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [W-1:0]     slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push, do_pop;

  assign ready   = (fill != CNT_W'(DEPTH));
  assign valid   = (fill != '0);
  assign data    = slots[rd_ptr];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/tos_back.sv =====
module tos_back #(
  parameter int NAME_MAX = tos_pkg::NAME_MAX_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  tos_pkg::entry_t q_entry,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_byte,
  output logic            name_truncated,
  output logic            out_last
);

  localparam int IDX_W = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;

  logic [7:0]                mem [NAME_MAX];
  logic [7:0]                rd_data;
  tos_pkg::phase_t           ph, ph_next, sel;
  logic [tos_pkg::CNT_W-1:0] k, k_next;
  logic [tos_pkg::NUM_PH-1:0] pres, masked;
  logic                      any, more_names, is_last, load;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_idx, rd_idx;
  logic [1:0]                kind_d;
  logic [7:0]                byte_d;
  logic                      trunc_d;

  assign more_names = (k + tos_pkg::CNT_W'(1)) < q_entry.name_count;

  // pick the next result of the head entry
  always_comb begin
    pres = '0;
    pres[tos_pkg::PH_CR]    = q_entry.cr_valid;
    pres[tos_pkg::PH_OPEN]  = q_entry.burst;
    pres[tos_pkg::PH_NAME]  = q_entry.burst && (k < q_entry.name_count);
    pres[tos_pkg::PH_CLOSE] = q_entry.burst;
    pres[tos_pkg::PH_NL]    = q_entry.burst;
    pres[tos_pkg::PH_MAIN]  = q_entry.main_valid;
    pres[tos_pkg::PH_END]   = q_entry.end_item;
    sel     = tos_pkg::PH_END;
    is_last = 1'b1;
    for (int i = 0; i < tos_pkg::NUM_PH; i++) begin
      masked[i] = pres[i] && (i >= int'(ph));
    end
    for (int i = tos_pkg::NUM_PH - 1; i >= 0; i--) begin
      if (masked[i]) begin
        sel = tos_pkg::phase_t'(i);
      end
    end
    for (int i = 0; i < tos_pkg::NUM_PH; i++) begin
      if (masked[i] && i > int'(sel)) begin
        is_last = 1'b0;
      end
    end
    if (sel == tos_pkg::PH_NAME && more_names) begin
      is_last = 1'b0;
    end
    any = |masked;
  end

  assign load  = q_valid && any && (!out_valid || out_ready);
  assign q_pop = q_valid && (!any || (load && is_last));

  // next phase
  always_comb begin
    ph_next = ph;
    k_next  = k;
    if (q_pop) begin
      ph_next = tos_pkg::PH_CR;
      k_next  = '0;
    end else if (load) begin
      if (sel == tos_pkg::PH_NAME && more_names) begin
        ph_next = tos_pkg::PH_NAME;
        k_next  = k + tos_pkg::CNT_W'(1);
      end else begin
        ph_next = tos_pkg::phase_t'(sel + 3'd1);
      end
    end
  end

  // result fields for the chosen phase
  always_comb begin
    kind_d  = tos_pkg::KIND_TEXT;
    byte_d  = 8'h00;
    trunc_d = 1'b0;
    unique case (sel)
      tos_pkg::PH_CR:    byte_d = q_entry.cr_byte;
      tos_pkg::PH_OPEN:  byte_d = tos_pkg::CHAR_LBR;
      tos_pkg::PH_NAME:  byte_d = rd_data;
      tos_pkg::PH_CLOSE: begin
        byte_d  = tos_pkg::CHAR_RBR;
        trunc_d = q_entry.name_ovf;
      end
      tos_pkg::PH_NL:    byte_d = tos_pkg::CHAR_LF;
      tos_pkg::PH_MAIN: begin
        kind_d = q_entry.main_kind;
        byte_d = q_entry.main_byte;
      end
      default:           kind_d = tos_pkg::KIND_END;
    endcase
  end

  assign wr_en  = q_pop && q_entry.store;
  assign wr_idx = q_entry.store_idx[IDX_W-1:0];
  assign rd_idx = k_next[IDX_W-1:0];

  // name store, read one entry ahead with write bypass
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= q_entry.store_byte;
    end
    if (wr_en && wr_idx == rd_idx) begin
      rd_data <= q_entry.store_byte;
    end else begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph        <= tos_pkg::PH_CR;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      ph        <= ph_next;
      k         <= k_next;
      out_valid <= load || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind       <= kind_d;
      out_byte       <= byte_d;
      name_truncated <= trunc_d;
      out_last       <= is_last;
    end
  end

endmodule

// ===== rtl/telnet_option_stripper_unit.sv =====
// an accepted byte's entry waits in the queue, then its first result is registered
// in the output register; one result per cycle while out_ready is high, and a byte
// giving no result is popped without output; a closed name window gives name length + 3 results
// the back end's single output register sets the pace, the queue absorbs bursts
// rst (synchronous) clears parser state, queue and output valid; the name
// store is not cleared and holds stale bytes until written
module telnet_option_stripper_unit #(
  parameter int NAME_MAX = tos_pkg::NAME_MAX_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       in_valid,
  output logic       in_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       name_truncated,
  output logic       out_last,
  output logic       out_valid,
  input  logic       out_ready
);

  localparam int ENTRY_W = $bits(tos_pkg::entry_t);

  // front to queue
  logic            push;
  logic            q_ready;
  tos_pkg::entry_t push_entry;
  // queue to back
  logic            q_valid;
  logic            q_pop;
  tos_pkg::entry_t head_entry;

  // front end: parses telnet commands, crlf state and the name window,
  // one transaction in per cycle while the queue has room
  tos_front #(
    .NAME_MAX (NAME_MAX)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .q_ready  (q_ready),
    .q_push   (push),
    .q_entry  (push_entry)
  );

  // short queue of work entries, one per accepted byte
  tos_queue #(
    .W     (ENTRY_W),
    .DEPTH (tos_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_entry),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (head_entry)
  );

  // back end: walks each entry's results in order and owns the name store
  tos_back #(
    .NAME_MAX (NAME_MAX)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_entry        (head_entry),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .name_truncated (name_truncated),
    .out_last       (out_last)
  );

endmodule
